// ===== rtl/dgrc_pkg.sv =====
// shared constants and types for the grid ray caster
package dgrc_pkg;

  localparam int MAP_SIZE_DEF  = 32;
  localparam int MAX_STEPS_DEF = 64;
  localparam int FRAC_BITS     = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // distances: 2F+8 bits covers delta_inf and accumulated sums
  localparam int DW = 2 * FRAC_BITS + 8;

  localparam logic [22:0] DIST_MIN = 23'(((1 << FRAC_BITS) + 9999) / 10000);
  localparam logic [22:0] DIST_MAX = 23'h7FFFFF;

  typedef logic [DW-1:0] dist_t;

endpackage

// ===== rtl/dda_grid_ray_cast.sv =====
// grid ray caster: solidity map, reciprocal divider, dda stepper, hit point unit
// write: taken while idle, busy stays low; cast: busy through the divider for x then y,
// the S_INIT setup, the stepping (map read, then compare per step)
// and S_FIN, S_MULX, S_MULY, S_OUT for clamp and hit point
// the result strobe rises in the same cycle that busy drops; the receiver cannot stall it
// one request at a time: a new request is not taken until the last cast is done
// reset clears control and then sweeps the map cell by cell, busy throughout
module dda_grid_ray_cast #(
  parameter int MAX_STEPS = dgrc_pkg::MAX_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [4:0]         in_write_cell_x,
  input  logic [4:0]         in_write_cell_y,
  input  logic               in_cell_solid,
  input  logic [20:0]        in_origin_x,
  input  logic [20:0]        in_origin_y,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic [21:0]        in_max_dist,
  output logic               out_valid,
  output logic               out_wall_hit,
  output logic [22:0]        out_hit_dist,
  output logic               out_hit_side,
  output logic signed [6:0]  out_end_cell_x,
  output logic signed [6:0]  out_end_cell_y,
  output logic signed [23:0] out_hit_point_x,
  output logic signed [23:0] out_hit_point_y
);
  localparam int MAP_SIZE = dgrc_pkg::MAP_SIZE_DEF;
  localparam int F   = dgrc_pkg::FRAC_BITS;
  localparam int DW  = dgrc_pkg::DW;
  localparam int CW  = $clog2(MAP_SIZE);
  localparam int AW  = 2 * CW;
  localparam int NC  = MAP_SIZE * MAP_SIZE;
  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int QW  = 2 * F + 1;
  localparam int DVW = $clog2(QW + 1);
  localparam int MW  = CW + 3;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_DIVX = 4'd2, S_DIVY = 4'd3,
    S_INIT = 4'd4, S_STEP = 4'd5, S_LOOK = 4'd6, S_FIN = 4'd7, S_MULX = 4'd8,
    S_MULY = 4'd9, S_OUT = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       mem_r [NC];
  logic       rd_r;
  logic [AW:0] clr_r;

  logic [20:0] ox_r, oy_r;
  logic signed [17:0] dx_r, dy_r;
  logic [21:0] maxd_r;
  dgrc_pkg::dist_t ddx_r, ddy_r, sdx_r, sdy_r;
  logic signed [MW-1:0] mx_r, my_r;
  logic side_r, hit_r;
  logic [SW-1:0] n_r;

  // restoring divider for 2^(2F) / |d|
  logic [QW:0]    rem_r;
  logic [QW-2:0]  quo_r;
  logic [DVW-1:0] dcnt_r;
  logic [17:0]    dmag;
  logic [QW:0]    rem_sh, rem_sub;
  logic [QW-1:0]  num_bit;

  logic [22:0] dist_r;
  logic signed [23:0] px_r;
  logic [41:0] prod_r;

  always_comb begin
    dmag = (state_r == S_DIVX) ? (dx_r[17] ? 18'(-dx_r) : dx_r)
                               : (dy_r[17] ? 18'(-dy_r) : dy_r);
    num_bit = QW'(1) << (2 * F);
    rem_sh = {rem_r[QW-1:0], num_bit[dcnt_r[DVW-1:0] - DVW'(1)]};
    rem_sub = rem_sh - (QW + 1)'(dmag);
  end

  // step choice
  logic xsel;
  dgrc_pkg::dist_t entry;
  logic signed [MW-1:0] nmx, nmy;
  logic in_map;
  logic [AW-1:0] raddr;
  always_comb begin
    xsel  = sdx_r < sdy_r;
    entry = xsel ? sdx_r : sdy_r;
    nmx = xsel ? (dx_r[17] ? mx_r - MW'(1) : mx_r + MW'(1)) : mx_r;
    nmy = xsel ? my_r : (dy_r[17] ? my_r - MW'(1) : my_r + MW'(1));
    in_map = (nmx >= 0) && (nmx < MAP_SIZE) && (nmy >= 0) && (nmy < MAP_SIZE);
    raddr = {nmy[CW-1:0], nmx[CW-1:0]};
  end

  // first boundary scaling: frac * delta >> F, done as one product
  logic [F:0] fx, fy;
  always_comb begin
    fx = dx_r[17] ? (F+1)'(ox_r[F-1:0]) : (F+1)'(1 << F) - (F+1)'(ox_r[F-1:0]);
    fy = dy_r[17] ? (F+1)'(oy_r[F-1:0]) : (F+1)'(1 << F) - (F+1)'(oy_r[F-1:0]);
  end

  dgrc_pkg::dist_t dist_raw;
  logic [22:0] dist_c;
  always_comb begin
    dist_raw = side_r ? sdy_r - ddy_r : sdx_r - ddx_r;
    if (dist_raw < DW'(dgrc_pkg::DIST_MIN)) dist_c = dgrc_pkg::DIST_MIN;
    else if (dist_raw > DW'(dgrc_pkg::DIST_MAX)) dist_c = dgrc_pkg::DIST_MAX;
    else dist_c = dist_raw[22:0];
  end

  // hit coordinate from product of |d| and dist
  function automatic logic signed [23:0] coord(input logic [20:0] o, input logic neg,
                                              input logic [41:0] p);
    logic [26:0] r;
    logic signed [28:0] v;
    begin
      r = 27'((p + 42'(1 << (F - 1))) >> F);
      v = neg ? 29'(o) - 29'(r) : 29'(o) + 29'(r);
      if (v > 29'sd8388607) coord = 24'sh7FFFFF;
      else if (v < -29'sd8388608) coord = -24'sd8388608;
      else coord = v[23:0];
    end
  endfunction

  logic [17:0] amx, amy;
  assign amx = dx_r[17] ? 18'(-dx_r) : dx_r;
  assign amy = dy_r[17] ? 18'(-dy_r) : dy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (AW+1)'(NC - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = (in_opcode == dgrc_pkg::OP_CAST) ? S_DIVX : S_IDLE;
      S_DIVX:  if (dcnt_r == DVW'(1)) state_nxt = S_DIVY;
      S_DIVY:  if (dcnt_r == DVW'(1)) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_STEP;
      S_STEP:  begin
        if (n_r == SW'(MAX_STEPS) || entry > DW'(maxd_r)) state_nxt = S_FIN;
        else if (!in_map) state_nxt = S_FIN;
        else state_nxt = S_LOOK;
      end
      S_LOOK:  state_nxt = rd_r ? S_FIN : S_STEP;
      S_FIN:   state_nxt = S_MULX;
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_OUT);
      if (state_r == S_CLEAR) clr_r <= clr_r + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem_r[clr_r[AW-1:0]] <= 1'b0;
    else if (state_r == S_IDLE && start && in_opcode == dgrc_pkg::OP_WRITE &&
             32'(in_write_cell_x) < MAP_SIZE && 32'(in_write_cell_y) < MAP_SIZE)
      mem_r[{in_write_cell_y[CW-1:0], in_write_cell_x[CW-1:0]}] <= in_cell_solid;
    rd_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ox_r <= in_origin_x; oy_r <= in_origin_y;
        dx_r <= in_dir_x; dy_r <= in_dir_y; maxd_r <= in_max_dist;
        rem_r <= '0; quo_r <= '0; dcnt_r <= DVW'(QW);
        hit_r <= 1'b0; side_r <= 1'b0; n_r <= '0;
      end
      S_DIVX, S_DIVY: begin
        if (dcnt_r == DVW'(1)) begin
          // last quotient bit goes straight into the delta
          rem_r <= '0; dcnt_r <= DVW'(QW);
          if (state_r == S_DIVX)
            ddx_r <= (dmag == '0) ? DW'(1) << (2 * F + 4)
                     : DW'({quo_r, rem_sh >= (QW + 1)'(dmag)});
          else
            ddy_r <= (dmag == '0) ? DW'(1) << (2 * F + 4)
                     : DW'({quo_r, rem_sh >= (QW + 1)'(dmag)});
        end else begin
          if (rem_sh >= (QW + 1)'(dmag)) begin
            rem_r <= rem_sub; quo_r <= {quo_r[QW-3:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quo_r <= {quo_r[QW-3:0], 1'b0};
          end
          dcnt_r <= dcnt_r - DVW'(1);
        end
      end
      S_INIT: begin
        sdx_r <= DW'((64'(ddx_r) * 64'(fx)) >> F);
        sdy_r <= DW'((64'(ddy_r) * 64'(fy)) >> F);
        mx_r <= MW'(ox_r[20:F]); my_r <= MW'(oy_r[20:F]);
      end
      S_STEP: begin
        if (n_r != SW'(MAX_STEPS)) begin
          side_r <= !xsel;
          if (xsel) sdx_r <= sdx_r + ddx_r; else sdy_r <= sdy_r + ddy_r;
          mx_r <= nmx; my_r <= nmy;
          n_r <= n_r + SW'(1);
          if (entry <= DW'(maxd_r) && !in_map) hit_r <= 1'b1;
        end
      end
      S_LOOK: if (rd_r) hit_r <= 1'b1;
      S_FIN:  dist_r <= dist_c;
      S_MULX: begin
        prod_r <= 42'(amx) * 42'(dist_r);
      end
      S_MULY: begin
        px_r <= coord(ox_r, dx_r[17], prod_r);
        prod_r <= 42'(amy) * 42'(dist_r);
      end
      S_OUT: begin
        out_wall_hit <= hit_r; out_hit_dist <= dist_r; out_hit_side <= side_r;
        out_end_cell_x <= 7'(mx_r); out_end_cell_y <= 7'(my_r);
        out_hit_point_x <= px_r;
        out_hit_point_y <= coord(oy_r, dy_r[17], prod_r);
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_valid_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_valid_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_OUT) else $error("stray result");
  a_dist_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_dist >= dgrc_pkg::DIST_MIN) else $error("distance not clamped");
endmodule

// ===== verif/dda_grid_ray_cast_test.sv =====
// testbench for the grid ray caster: directed and random casts against a local predictor
`timescale 1ns / 1ps

module dda_grid_ray_cast_test;

  typedef struct {
    logic               op;
    logic [4:0]         wx;
    logic [4:0]         wy;
    logic               solid;
    logic [20:0]        ox;
    logic [20:0]        oy;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic [21:0]        maxd;
  } req_t;

  typedef struct {
    logic        hit;
    logic [22:0] span;
    logic        side;
    logic [6:0]  cx;
    logic [6:0]  cy;
    logic [23:0] px;
    logic [23:0] py;
  } cast_res_t;

  localparam int GRID = 32;
  localparam int STEPS = 64;
  localparam longint ONE = 64'd1 << dgrc_pkg::FRAC_BITS;
  localparam longint FMASK = ONE - 1;
  localparam longint DELTA_HUGE = 64'd1 << (2 * dgrc_pkg::FRAC_BITS + 4);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = dgrc_pkg::OP_WRITE;
  logic [4:0] in_write_cell_x = '0;
  logic [4:0] in_write_cell_y = '0;
  logic in_cell_solid = 1'b0;
  logic [20:0] in_origin_x = '0;
  logic [20:0] in_origin_y = '0;
  logic signed [17:0] in_dir_x = '0;
  logic signed [17:0] in_dir_y = '0;
  logic [21:0] in_max_dist = '0;
  logic out_valid, out_wall_hit, out_hit_side;
  logic [22:0] out_hit_dist;
  logic signed [6:0] out_end_cell_x, out_end_cell_y;
  logic signed [23:0] out_hit_point_x, out_hit_point_y;

  bit solid_cells [0:GRID*GRID-1];
  cast_res_t expected_casts[$];
  int errors = 0;
  int idle_pct = 0;
  int casts_sent = 0, writes_sent = 0, hits_seen = 0, results_seen = 0;

  dda_grid_ray_cast dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint step_len(longint d);
    longint mag;
    if (d == 0) return DELTA_HUGE;
    mag = d < 0 ? -d : d;
    return (64'd1 << (2 * dgrc_pkg::FRAC_BITS)) / mag;
  endfunction

  function automatic longint frac_scale(longint frac, longint delta);
    return (delta >>> dgrc_pkg::FRAC_BITS) * frac +
           (((delta & FMASK) * frac) >>> dgrc_pkg::FRAC_BITS);
  endfunction

  function automatic longint point_coord(longint o, longint d, longint span);
    longint mag, r, v;
    mag = (d < 0 ? -d : d) * span;
    r = (mag + (ONE >>> 1)) >>> dgrc_pkg::FRAC_BITS;
    v = o + (d < 0 ? -r : r);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic bit blocked(longint x, longint y);
    if (x < 0 || y < 0 || x >= GRID || y >= GRID) return 1'b1;
    return solid_cells[y * GRID + x];
  endfunction

  function automatic cast_res_t trace_ray(req_t r);
    cast_res_t res;
    longint ox, oy, dx, dy, maxd, ddx, ddy, sdx, sdy, span, entry, mx, my;
    int sx, sy;
    bit side, hit;
    ox = r.ox; oy = r.oy; dx = r.dx; dy = r.dy; maxd = r.maxd;
    mx = ox >>> dgrc_pkg::FRAC_BITS;
    my = oy >>> dgrc_pkg::FRAC_BITS;
    ddx = step_len(dx);
    ddy = step_len(dy);
    side = 0; hit = 0;
    if (dx < 0) begin
      sx = -1; sdx = frac_scale(ox & FMASK, ddx);
    end else begin
      sx = 1; sdx = frac_scale(ONE - (ox & FMASK), ddx);
    end
    if (dy < 0) begin
      sy = -1; sdy = frac_scale(oy & FMASK, ddy);
    end else begin
      sy = 1; sdy = frac_scale(ONE - (oy & FMASK), ddy);
    end
    for (int n = 0; n < STEPS; n++) begin
      // ties go to the y axis
      if (sdx < sdy) begin
        entry = sdx; sdx += ddx; mx += sx; side = 0;
      end else begin
        entry = sdy; sdy += ddy; my += sy; side = 1;
      end
      if (entry > maxd) break;
      if (blocked(mx, my)) begin
        hit = 1;
        break;
      end
    end
    span = side ? sdy - ddy : sdx - ddx;
    if (span < longint'(dgrc_pkg::DIST_MIN)) span = dgrc_pkg::DIST_MIN;
    if (span > longint'(dgrc_pkg::DIST_MAX)) span = dgrc_pkg::DIST_MAX;
    res.hit = hit;
    res.span = span[22:0];
    res.side = side;
    res.cx = mx[6:0];
    res.cy = my[6:0];
    res.px = 24'(point_coord(ox, dx, span));
    res.py = 24'(point_coord(oy, dy, span));
    return res;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  // result checker: no back pressure, every strobe is a result
  always @(posedge clk) begin
    cast_res_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_casts.size() == 0) begin
        report_mismatch("unexpected result", 0, out_hit_dist);
      end else begin
        e = expected_casts.pop_front();
        if (out_wall_hit) hits_seen++;
        if (out_wall_hit !== e.hit) report_mismatch("wall_hit", e.hit, out_wall_hit);
        if (out_hit_dist !== e.span) report_mismatch("hit_dist", e.span, out_hit_dist);
        if (out_hit_side !== e.side) report_mismatch("hit_side", e.side, out_hit_side);
        if (out_end_cell_x !== e.cx) report_mismatch("end_cell_x", e.cx, out_end_cell_x);
        if (out_end_cell_y !== e.cy) report_mismatch("end_cell_y", e.cy, out_end_cell_y);
        if (out_hit_point_x !== e.px) report_mismatch("hit_point_x", e.px, out_hit_point_x);
        if (out_hit_point_y !== e.py) report_mismatch("hit_point_y", e.py, out_hit_point_y);
      end
    end
  end

  // called at a rising edge; leaves start high so back-to-back requests need no gap
  task automatic send_request(req_t r);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= r.op;
    in_write_cell_x <= r.wx;
    in_write_cell_y <= r.wy;
    in_cell_solid <= r.solid;
    in_origin_x <= r.ox;
    in_origin_y <= r.oy;
    in_dir_x <= r.dx;
    in_dir_y <= r.dy;
    in_max_dist <= r.maxd;
    do @(posedge clk); while (busy);
    if (r.op == dgrc_pkg::OP_WRITE) begin
      solid_cells[r.wy * GRID + r.wx] = r.solid;
      writes_sent++;
    end else begin
      expected_casts.push_back(trace_ray(r));
      casts_sent++;
    end
  endtask

  task automatic write_cell(int x, int y, bit s);
    req_t r;
    r = '{default: '0};
    r.op = dgrc_pkg::OP_WRITE; r.wx = 5'(x); r.wy = 5'(y); r.solid = s;
    r.ox = 21'($urandom); r.oy = 21'($urandom); r.dx = 18'($urandom); r.dy = 18'($urandom);
    send_request(r);
  endtask

  task automatic cast_ray(int ox, int oy, int dx, int dy, int maxd);
    req_t r;
    r.op = dgrc_pkg::OP_CAST; r.wx = 5'($urandom); r.wy = 5'($urandom);
    r.solid = 1'($urandom);
    r.ox = 21'(ox); r.oy = 21'(oy); r.dx = 18'(dx); r.dy = 18'(dy); r.maxd = 22'(maxd);
    send_request(r);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((busy || expected_casts.size() != 0) && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  function automatic int rand_dir();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(1) ? 65536 : -65536;
      2: return $urandom_range(1, 16) * ($urandom_range(1) ? 1 : -1);
      3: return $signed(18'($urandom));
      default: return int'($urandom_range(131072)) - 65536;
    endcase
  endfunction

  task automatic test_extremes();
    cast_ray(0, 0, 0, 0, 0);
    cast_ray(2097151, 2097151, 65536, 65536, 4194303);
    cast_ray(2097151, 2097151, -65536, -65536, 4194303);
    cast_ray(16 << 16, 16 << 16, 65536, 0, 4194303);
    cast_ray(16 << 16, 16 << 16, 0, -65536, 4194303);
    // equal deltas from a cell center: the y axis wins every tie
    cast_ray((5 << 16) + 32768, (5 << 16) + 32768, 46341, 46341, 4194303);
    // near-zero component: distance is clamped up to DIST_MIN
    cast_ray(3 << 16, 3 << 16, 0, 1, 4194303);
    cast_ray(3 << 16, 3 << 16, -1, 0, 4194303);
    cast_ray(0, 10 << 16, -65536, 3, 4194303);
    // origin on a boundary moving toward -x: zero distance gets clamped
    write_cell(7, 8, 1);
    cast_ray(8 << 16, (8 << 16) + 100, -65536, 0, 100);
    cast_ray(8 << 16, 8 << 16, -131072, 131071, 4194303);
    cast_ray(100, 2097151, 131071, -131072, 1);
    write_cell(7, 8, 0);
    write_cell(31, 31, 1);
    write_cell(0, 0, 1);
    cast_ray(1 << 16, 1 << 16, -40000, -40000, 4194303);
    write_cell(31, 31, 0);
    write_cell(0, 0, 0);
  endtask

  task automatic test_doors();
    write_cell(12, 4, 1);
    cast_ray((4 << 16) + 30000, (4 << 16) + 20000, 65536, 0, 4194303);
    write_cell(12, 4, 0);
    cast_ray((4 << 16) + 30000, (4 << 16) + 20000, 65536, 0, 4194303);
    write_cell(12, 4, 1);
    cast_ray((4 << 16) + 30000, (4 << 16) + 20000, 65536, 0, 5 << 16);
    write_cell(12, 4, 0);
  endtask

  // rooms of random walls written, then bursts of casts through them
  task automatic test_random(int items, int pct);
    int sent, k;
    idle_pct = pct;
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(0, 6);
      repeat (k) begin
        write_cell($urandom_range(31), $urandom_range(31), $urandom_range(2) == 0);
        sent++;
      end
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(3) == 0)
          cast_ray($urandom_range(2097151), $urandom_range(2097151), rand_dir(),
                   rand_dir(), $urandom_range(4194303));
        else
          cast_ray($urandom_range(2097151), $urandom_range(2097151), rand_dir(),
                   rand_dir(), $urandom_range(1) ? 4194303 : $urandom_range(20 << 16));
        sent++;
      end
      if ($urandom_range(60) == 0) drain_results();
    end
    drain_results();
    idle_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_doors();
    drain_results();
    test_random(400, 0);
    test_random(400, 47);
    test_random(400, 0);
    test_random(400, 26);
    drain_results();
    if (expected_casts.size() != 0)
      report_mismatch("results missing", expected_casts.size(), 0);
    $display("covered %0d cell writes and %0d casts, %0d results with %0d wall hits",
             writes_sent, casts_sent, results_seen, hits_seen);
    if (errors == 0)
      $display("dda_grid_ray_cast test passed");
    else
      $display("dda_grid_ray_cast test failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("dda_grid_ray_cast test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dgrc_pkg.sv
rtl/dda_grid_ray_cast.sv
verif/dda_grid_ray_cast_test.sv
